[rtl/core/upx2_pkg.sv]
// Package for the 2x image upscaler: request/result types, sizes, filter codes,
// tap weight tables and small helpers. No dependencies.
package upx2_pkg;

    // Image memory geometry
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int XB         = $clog2(MAX_WIDTH);
    localparam int YB         = $clog2(MAX_HEIGHT);
    localparam int AXIS_BITS  = $clog2(MAX_DIM);
    localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
    localparam int CMP_BITS   = DIM_BITS + 2;
    localparam int ADDR_BITS  = XB + YB;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;

    // Datapath sizes
    localparam int TAPS         = 4;
    localparam int NUM_CH       = 3;
    localparam int CH_BITS      = 8;
    localparam int PIX_BITS     = NUM_CH * CH_BITS;
    localparam int WEIGHT_BITS  = 9;
    localparam int WPROD_BITS   = 16;
    localparam int ACC_BITS     = 26;
    localparam int RND_BITS     = ACC_BITS + 1;
    localparam int FRAC_BITS    = 14;
    localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);
    localparam int CH_MAX       = (1 << CH_BITS) - 1;
    localparam int TAP_CNT_BITS = 4;
    localparam logic [TAP_CNT_BITS-1:0] TAP_LAST = TAP_CNT_BITS'(TAPS * TAPS - 1);

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int MODE_BITS     = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT  = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_NEAREST  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BILINEAR = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BICUBIC  = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RST_FILTER_MODE = CFG_DATA_BITS'(MODE_BICUBIC);
    localparam logic [CFG_DATA_BITS-1:0] RST_SRC_WIDTH   = 8'd128;
    localparam logic [CFG_DATA_BITS-1:0] RST_SRC_HEIGHT  = 8'd128;

    // Request function codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       coord_error;
    } result_t;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [WPROD_BITS-1:0]  wprod_t;

    // Fractional phase of one axis: t = 0, 1/4 or 3/4
    typedef enum logic [1:0] {
        TSEL_ONE,
        TSEL_QTR,
        TSEL_TQ
    } tsel_t;

    // Clamped tap positions and weights (over 128) of one axis
    typedef struct packed {
        logic [TAPS-1:0][AXIS_BITS-1:0] pos;
        weight_t [TAPS-1:0]              wt;
    } axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_ROUND
    } state_t;

    localparam weight_t ONE_TAP [TAPS] = '{9'sd0, 9'sd128, 9'sd0, 9'sd0};
    localparam weight_t LIN_QTR [TAPS] = '{9'sd0, 9'sd96, 9'sd32, 9'sd0};
    localparam weight_t LIN_TQ  [TAPS] = '{9'sd0, 9'sd32, 9'sd96, 9'sd0};
    localparam weight_t CUB_QTR [TAPS] = '{-9'sd9, 9'sd111, 9'sd29, -9'sd3};
    localparam weight_t CUB_TQ  [TAPS] = '{-9'sd3, 9'sd29, 9'sd111, -9'sd9};

    // Size register saturated to 1..maxv
    function automatic logic [DIM_BITS-1:0] eff_size(input logic [CFG_DATA_BITS-1:0] r,
                                                     input int maxv);
        logic [DIM_BITS-1:0] s;
        if (r == '0)
            s = DIM_BITS'(1);
        else if (int'(r) > maxv)
            s = DIM_BITS'(maxv);
        else
            s = DIM_BITS'(r);
        return s;
    endfunction

    // Modes other than nearest and bilinear are treated as bicubic
    function automatic weight_t tap_weight(input logic [MODE_BITS-1:0] mode,
                                           input tsel_t tsel,
                                           input logic [1:0] idx);
        weight_t w;
        if (tsel == TSEL_ONE)
            w = ONE_TAP[idx];
        else if (mode == MODE_BILINEAR)
            w = (tsel == TSEL_QTR) ? LIN_QTR[idx] : LIN_TQ[idx];
        else
            w = (tsel == TSEL_QTR) ? CUB_QTR[idx] : CUB_TQ[idx];
        return w;
    endfunction

endpackage

[rtl/core/upx2_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module upx2_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rdata = rd_data_reg;

endmodule

[rtl/core/upx2_axis.sv]
// Per-axis setup: maps a destination coordinate to TAPS edge-clamped source taps
// and their weights. Depends on upx2_pkg.
module upx2_axis (
    input  logic [7:0]                    coord,
    input  logic [upx2_pkg::DIM_BITS-1:0] size,
    input  logic [upx2_pkg::MODE_BITS-1:0] mode,
    output upx2_pkg::axis_t               taps
);
    import upx2_pkg::*;

    always_comb
    begin
        int    k;
        int    last;
        int    base;
        int    p;
        tsel_t tsel;

        k    = int'(coord) >> 1;
        last = int'(size) - 1;

        if (mode == MODE_NEAREST)
        begin
            base = k;
            tsel = TSEL_ONE;
        end
        else if (coord[0] == 1'b0)
        begin
            // even column sits 3/4 past the previous source pixel
            if (k == 0)
            begin
                base = 0;
                tsel = TSEL_ONE;
            end
            else
            begin
                base = k - 1;
                tsel = TSEL_TQ;
            end
        end
        else
        begin
            // odd column, clamped at the far edge
            if (k >= last)
            begin
                base = last;
                tsel = TSEL_ONE;
            end
            else
            begin
                base = k;
                tsel = TSEL_QTR;
            end
        end

        for (int i = 0; i < TAPS; i++)
        begin
            p = base + i - 1;
            if (p < 0)
                p = 0;
            if (p > last)
                p = last;
            taps.pos[i] = AXIS_BITS'(p);
            taps.wt[i]  = tap_weight(mode, tsel, 2'(i));
        end
    end

endmodule

[rtl/core/upx2_mac.sv]
// Three-channel multiply-accumulate with round-half-up and 0..255 saturation.
// Depends on upx2_pkg.
module upx2_mac (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        clear,
    input  logic                                        en,
    input  upx2_pkg::wprod_t                            wprod,
    input  logic [upx2_pkg::PIX_BITS-1:0]               pixel,
    output logic [upx2_pkg::NUM_CH-1:0][upx2_pkg::CH_BITS-1:0] chan
);
    import upx2_pkg::*;

    logic signed [ACC_BITS-1:0] acc_reg  [NUM_CH];
    logic signed [ACC_BITS-1:0] acc_next [NUM_CH];

    // chan[0] is red (pixel bits 23..16)
    always_comb
    begin
        logic signed [CH_BITS:0]            pix_s;
        logic signed [WPROD_BITS+CH_BITS:0] prod;
        logic signed [RND_BITS-1:0]         rnd;
        logic        [RND_BITS-1:0]         shifted;

        for (int c = 0; c < NUM_CH; c++)
        begin
            pix_s = $signed({1'b0, pixel[PIX_BITS-1-CH_BITS*c -: CH_BITS]});
            prod  = (WPROD_BITS+CH_BITS+1)'(wprod) * (WPROD_BITS+CH_BITS+1)'(pix_s);
            if (clear)
                acc_next[c] = '0;
            else if (en)
                acc_next[c] = acc_reg[c] + ACC_BITS'(prod);
            else
                acc_next[c] = acc_reg[c];

            rnd     = RND_BITS'(acc_reg[c]) + RND_BITS'(ROUND_HALF);
            shifted = RND_BITS'(rnd >>> FRAC_BITS);
            if (rnd[RND_BITS-1])
                chan[c] = '0;
            else if (shifted > RND_BITS'(CH_MAX))
                chan[c] = CH_BITS'(CH_MAX);
            else
                chan[c] = shifted[CH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
                acc_reg[c] <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
                acc_reg[c] <= acc_next[c];
        end
    end

endmodule

[rtl/core/image_upscale_2x_bicubic.sv]
// 2x RGB upscaler (nearest / bilinear / Catmull-Rom bicubic) over a 128x128 source memory.
// Pixel write request: busy stays low, result strobe on the next cycle.
// Compute request: 16 taps read from the single-port image RAM, one per cycle, then a
// final MAC and rounding before done; out-of-range computes answer next cycle.
// Reset clears control and config (bicubic, 128x128); image contents are undefined.
// Results are strobed for one cycle on done; the receiver cannot stall.
module image_upscale_2x_bicubic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  upx2_pkg::cmd_t                     cmd,
    output logic                               done,
    output upx2_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [upx2_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [upx2_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import upx2_pkg::*;

    // Configuration registers
    logic [MODE_BITS-1:0]     filter_mode_reg;
    logic [CFG_DATA_BITS-1:0] src_width_reg;
    logic [CFG_DATA_BITS-1:0] src_height_reg;

    // Control
    state_t                  state_reg, state_next;
    logic [TAP_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    done_reg, done_next;
    result_t                 result_reg, result_next;
    wprod_t                  wprod_reg, wprod_next;
    logic                    job_start;

    // Latched tap sets of the job in flight
    axis_t axis_x, axis_y;
    axis_t axis_x_reg, axis_y_reg;

    logic [DIM_BITS-1:0]  w_eff, h_eff;
    logic                 accept;
    logic                 wr_ok, cmp_ok;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr, wr_addr, rd_addr;
    logic [PIX_BITS-1:0]  ram_rdata;
    logic [1:0]           x_idx, y_idx;
    logic [NUM_CH-1:0][CH_BITS-1:0] chan;

    assign w_eff  = eff_size(src_width_reg, MAX_WIDTH);
    assign h_eff  = eff_size(src_height_reg, MAX_HEIGHT);
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Writes must land inside the source; computes inside the 2x destination.
    assign wr_ok  = (CMP_BITS'(cmd.pos_x) < CMP_BITS'(w_eff)) &&
                    (CMP_BITS'(cmd.pos_y) < CMP_BITS'(h_eff));
    assign cmp_ok = (CMP_BITS'(cmd.pos_x) < CMP_BITS'({w_eff, 1'b0})) &&
                    (CMP_BITS'(cmd.pos_y) < CMP_BITS'({h_eff, 1'b0}));

    upx2_axis u_axis_x (
        .coord (cmd.pos_x),
        .size  (w_eff),
        .mode  (filter_mode_reg),
        .taps  (axis_x)
    );

    upx2_axis u_axis_y (
        .coord (cmd.pos_y),
        .size  (h_eff),
        .mode  (filter_mode_reg),
        .taps  (axis_y)
    );

    // Tap walk: x is the fast index, y the slow one.
    assign x_idx   = cnt_reg[1:0];
    assign y_idx   = cnt_reg[3:2];
    assign rd_addr = {axis_y_reg.pos[y_idx][YB-1:0], axis_x_reg.pos[x_idx][XB-1:0]};
    assign wr_addr = {YB'(cmd.pos_y), XB'(cmd.pos_x)};

    // Single port: pixel writes only happen in idle, tap reads only during a job.
    assign ram_we   = accept && (cmd.func == FUNC_WRITE) && wr_ok;
    assign ram_addr = (state_reg == ST_IDLE) ? wr_addr : rd_addr;

    upx2_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({cmd.in_red, cmd.in_green, cmd.in_blue}),
        .rdata (ram_rdata)
    );

    // Weight product is registered with the read, so RAM data and weight reach the MAC together.
    upx2_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (job_start),
        .en     (rd_valid_reg),
        .wprod  (wprod_reg),
        .pixel  (ram_rdata),
        .chan   (chan)
    );

    // Config write decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= RST_FILTER_MODE[MODE_BITS-1:0];
            src_width_reg   <= RST_SRC_WIDTH;
            src_height_reg  <= RST_SRC_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_MODE: filter_mode_reg <= cfg_data[MODE_BITS-1:0];
                CFG_SRC_WIDTH:   src_width_reg   <= cfg_data;
                CFG_SRC_HEIGHT:  src_height_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer: IDLE -> RUN (16 reads) -> LAST (final MAC) -> ROUND (result out)
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        result_next   = result_reg;
        wprod_next    = wprod_reg;
        job_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_WRITE)
                    begin
                        done_next               = 1'b1;
                        result_next             = '0;
                        result_next.coord_error = !wr_ok;
                    end
                    else if (!cmp_ok)
                    begin
                        done_next               = 1'b1;
                        result_next             = '0;
                        result_next.coord_error = 1'b1;
                    end
                    else
                    begin
                        job_start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rd_valid_next = 1'b1;
                wprod_next    = WPROD_BITS'(axis_x_reg.wt[x_idx]) *
                                WPROD_BITS'(axis_y_reg.wt[y_idx]);
                cnt_next      = cnt_reg + TAP_CNT_BITS'(1);
                if (cnt_reg == TAP_LAST)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                done_next               = 1'b1;
                result_next.out_red     = chan[0];
                result_next.out_green   = chan[1];
                result_next.out_blue    = chan[2];
                result_next.coord_error = 1'b0;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        wprod_reg  <= wprod_next;
        if (job_start)
        begin
            axis_x_reg <= axis_x;
            axis_y_reg <= axis_y;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Image writes never collide with a job's tap reads
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("image write while a compute request is reading taps");

    // Tap counter idles at zero outside the read phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (cnt_reg == '0))
        else $error("tap counter not parked at zero");

    // Rounding state always produces exactly one strobe and frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |=> (done && !busy))
        else $error("missing result after rounding");

    // A write request answers on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.func == FUNC_WRITE)) |=> done)
        else $error("write request not answered");

    // Errored results carry zero channels
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.coord_error) |->
            ((result.out_red == '0) && (result.out_green == '0) && (result.out_blue == '0)))
        else $error("coordinate error with nonzero channels");

endmodule

[tb/sv/image_upscale_2x_bicubic_test.sv]
// Self-checking bench for the 2x RGB upscaler: pixel write and compute requests,
// all filter modes and a range of size settings, checked against a built-in bit-exact predictor.
// Depends on upx2_pkg (request/result structs, config indexes, mode and function codes).
`timescale 1ns / 100ps

module image_upscale_2x_bicubic_test;

    import upx2_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 50;

    // What the request feeder does with one backlog entry
    typedef enum logic [1:0] {
        ENT_REQ,        // issue a request on start/cmd
        ENT_CFG,        // one register write, only with nothing in flight
        ENT_DRAIN       // hold off until every result is back
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t               kind;
        cmd_t                      cmd;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [6:0]                gap;     // chance in percent of idling per cycle
    } backlog_t;

    // Tap positions of one axis plus the fractional phase that picks the weights
    typedef struct packed {
        logic [3:0][6:0] pos;
        tsel_t           ph;
    } axis_taps_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    cmd_t                     cmd       = '0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     busy;
    logic                     done;
    result_t                  result;

    image_upscale_2x_bicubic uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow of the image RAM and of the three registers
    // ------------------------------------------------------------------
    logic [23:0]              image_ref [MEM_DEPTH];
    logic [1:0]               mode_cfg   = RST_FILTER_MODE[1:0];
    logic [CFG_DATA_BITS-1:0] width_cfg  = RST_SRC_WIDTH;
    logic [CFG_DATA_BITS-1:0] height_cfg = RST_SRC_HEIGHT;

    backlog_t cmd_backlog [$];      // requests and register writes still to issue
    result_t  due_pixels [$];       // predicted results, oldest first

    logic req_taken = 1'b0;         // request accepted at the last rising edge

    int err_count   = 0;
    int cycle_count = 0;
    int n_writes    = 0;
    int n_computes  = 0;
    int n_oob       = 0;
    int n_cfg       = 0;
    int comp_by_mode [4] = '{0, 0, 0, 0};

    // Stimulus builder's own view of config and of which pixels hold data
    bit         seeded [MEM_DEPTH];
    logic [1:0] gen_mode = RST_FILTER_MODE[1:0];
    int         gen_w = MAX_WIDTH;
    int         gen_h = MAX_HEIGHT;
    int         cur_gap = 0;
    int         req_queued = 0;

    // Size register saturated into 1..maxv
    function automatic int eff_dim(input int r, input int maxv);
        if (r == 0)
            return 1;
        return (r > maxv) ? maxv : r;
    endfunction

    // Per-tap weight over 128; the 3/4 phase is the 1/4 table mirrored
    function automatic int lobe(input logic [1:0] mode, input tsel_t ph, input int i);
        int j;
        int w;
        j = (ph == TSEL_TQ) ? 3 - i : i;
        if (ph == TSEL_ONE)
            w = (i == 1) ? 128 : 0;
        else if (mode == MODE_BILINEAR)
            w = (j == 1) ? 96 : (j == 2) ? 32 : 0;
        else
        begin
            case (j)
                0:       w = -9;
                1:       w = 111;
                2:       w = 29;
                default: w = -3;
            endcase
        end
        return w;
    endfunction

    // Destination coordinate d -> edge-clamped source taps t.pos and a phase.
    // The phase is t = 0 in nearest mode and at the first even and last odd coordinate.
    function automatic axis_taps_t axis_taps(input int d, input int n, input logic [1:0] mode);
        axis_taps_t t;
        int k;
        int base;
        int p;
        int i;
        k = d / 2;
        if (mode == MODE_NEAREST)
        begin
            base = k;
            t.ph = TSEL_ONE;
        end
        else if (d % 2 == 0)
        begin
            if (k == 0)
            begin
                base = 0;
                t.ph = TSEL_ONE;
            end
            else
            begin
                base = k - 1;
                t.ph = TSEL_TQ;
            end
        end
        else if (k >= n - 1)
        begin
            base = n - 1;
            t.ph = TSEL_ONE;
        end
        else
        begin
            base = k;
            t.ph = TSEL_QTR;
        end
        for (i = 0; i < 4; i++)
        begin
            p = base + i - 1;
            if (p < 0)
                p = 0;
            if (p > n - 1)
                p = n - 1;
            t.pos[i] = 7'(p);
        end
        return t;
    endfunction

    // Fixed point /16384, round half up, clip to a channel
    function automatic logic [7:0] to_channel(input int acc);
        int v;
        v = acc + ROUND_HALF;
        if (v < 0)
            return 8'd0;
        v = v >>> FRAC_BITS;
        return (v > CH_MAX) ? 8'd255 : 8'(v);
    endfunction

    // Expected result of one request; a write also updates the shadow RAM
    function automatic result_t upscale_pixel(input cmd_t c);
        result_t    r;
        axis_taps_t tx;
        axis_taps_t ty;
        int         w;
        int         h;
        int         i;
        int         j;
        int         wgt;
        int         acc_r;
        int         acc_g;
        int         acc_b;
        logic [23:0] pix;
        r = '0;
        w = eff_dim(int'(width_cfg), MAX_WIDTH);
        h = eff_dim(int'(height_cfg), MAX_HEIGHT);
        if (c.func == FUNC_WRITE)
        begin
            if (c.pos_x >= w || c.pos_y >= h)
                r.coord_error = 1'b1;
            else
                image_ref[int'(c.pos_y) * MAX_WIDTH + int'(c.pos_x)] =
                    {c.in_red, c.in_green, c.in_blue};
            return r;
        end
        if (c.pos_x >= 2 * w || c.pos_y >= 2 * h)
        begin
            r.coord_error = 1'b1;
            return r;
        end
        tx = axis_taps(int'(c.pos_x), w, mode_cfg);
        ty = axis_taps(int'(c.pos_y), h, mode_cfg);
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (j = 0; j < 4; j++)
        begin
            for (i = 0; i < 4; i++)
            begin
                wgt = lobe(mode_cfg, tx.ph, i) * lobe(mode_cfg, ty.ph, j);
                pix = image_ref[int'(ty.pos[j]) * MAX_WIDTH + int'(tx.pos[i])];
                acc_r += wgt * int'(pix[23:16]);
                acc_g += wgt * int'(pix[15:8]);
                acc_b += wgt * int'(pix[7:0]);
            end
        end
        r.out_red   = to_channel(acc_r);
        r.out_green = to_channel(acc_g);
        r.out_blue  = to_channel(acc_b);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders (run at time zero, fill the backlog)
    // ------------------------------------------------------------------
    // Mostly uniform random values, but pin 0 and 255 often so that the
    // bicubic lobes clip on both ends.
    function automatic logic [7:0] chan();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_request(input cmd_t c);
        backlog_t e;
        e = '0;
        e.kind = ENT_REQ;
        e.cmd  = c;
        e.gap  = 7'(cur_gap);
        cmd_backlog.push_back(e);
        req_queued++;
        if (c.func == FUNC_WRITE && c.pos_x < gen_w && c.pos_y < gen_h)
            seeded[int'(c.pos_y) * MAX_WIDTH + int'(c.pos_x)] = 1'b1;
    endtask

    task automatic add_write(input int x, input int y, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
        cmd_t c;
        c.func     = FUNC_WRITE;
        c.pos_x    = 8'(x);
        c.pos_y    = 8'(y);
        c.in_red   = red;
        c.in_green = green;
        c.in_blue  = blue;
        add_request(c);
    endtask

    // A compute reads all sixteen taps, zero weight or not, so every
    // footprint pixel gets written first if it never was.
    task automatic add_compute(input int x, input int y);
        cmd_t       c;
        axis_taps_t tx;
        axis_taps_t ty;
        int         i;
        int         j;
        if (x < 2 * gen_w && y < 2 * gen_h)
        begin
            tx = axis_taps(x, gen_w, gen_mode);
            ty = axis_taps(y, gen_h, gen_mode);
            for (j = 0; j < 4; j++)
                for (i = 0; i < 4; i++)
                    if (!seeded[int'(ty.pos[j]) * MAX_WIDTH + int'(tx.pos[i])])
                        add_write(int'(tx.pos[i]), int'(ty.pos[j]), chan(), chan(), chan());
        end
        c.func     = FUNC_COMPUTE;
        c.pos_x    = 8'(x);
        c.pos_y    = 8'(y);
        c.in_red   = 8'($urandom_range(255));     // ignored by computes
        c.in_green = 8'($urandom_range(255));
        c.in_blue  = 8'($urandom_range(255));
        add_request(c);
    endtask

    task automatic add_config(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
        backlog_t e;
        e = '0;
        e.kind = ENT_CFG;
        e.idx  = idx;
        e.data = data;
        cmd_backlog.push_back(e);
        case (idx)
            CFG_FILTER_MODE: gen_mode = data[1:0];
            CFG_SRC_WIDTH:   gen_w = eff_dim(int'(data), MAX_WIDTH);
            CFG_SRC_HEIGHT:  gen_h = eff_dim(int'(data), MAX_HEIGHT);
            default: ;
        endcase
    endtask

    task automatic add_drain();
        backlog_t e;
        e = '0;
        e.kind = ENT_DRAIN;
        cmd_backlog.push_back(e);
    endtask

    // One config setting followed by n random requests, mostly in range,
    // with a full drain halfway through.
    task automatic random_phase(input logic [1:0] mode, input int wreg, input int hreg,
                                input int n);
        int first;
        int roll;
        bit drained;
        add_config(CFG_FILTER_MODE, CFG_DATA_BITS'(mode));
        add_config(CFG_SRC_WIDTH, CFG_DATA_BITS'(wreg));
        add_config(CFG_SRC_HEIGHT, CFG_DATA_BITS'(hreg));
        first = req_queued;
        drained = 1'b0;
        while (req_queued - first < n)
        begin
            if (!drained && req_queued - first >= n / 2)
            begin
                add_drain();
                drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 35)
                add_write($urandom_range(gen_w - 1), $urandom_range(gen_h - 1),
                          chan(), chan(), chan());
            else if (roll < 40)
                add_write($urandom_range(255), $urandom_range(255), chan(), chan(), chan());
            else if (roll < 93)
                add_compute($urandom_range(2 * gen_w - 1), $urandom_range(2 * gen_h - 1));
            else
                add_compute($urandom_range(255), $urandom_range(255));
        end
    endtask

    // ------------------------------------------------------------------
    // Request feeder: changes inputs on the falling edge only. start is
    // held until the request is taken; register writes and drains wait
    // until nothing is in flight.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        backlog_t e;
        logic     nxt_start;
        logic     nxt_we;
        if (rst_n)
        begin
            nxt_start = start && !req_taken;
            nxt_we    = 1'b0;
            if (!nxt_start && cmd_backlog.size() != 0)
            begin
                e = cmd_backlog[0];
                case (e.kind)
                    ENT_REQ:
                        if ($urandom_range(99) >= e.gap)
                        begin
                            cmd <= e.cmd;
                            nxt_start = 1'b1;
                            void'(cmd_backlog.pop_front());
                        end
                    ENT_CFG:
                        if (due_pixels.size() == 0 && !busy)
                        begin
                            cfg_index <= e.idx;
                            cfg_data  <= e.data;
                            nxt_we = 1'b1;
                            void'(cmd_backlog.pop_front());
                        end
                    default:
                        if (due_pixels.size() == 0 && !busy)
                            void'(cmd_backlog.pop_front());
                endcase
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge retire a strobed result against the
    // oldest prediction, then predict for a request taken at this edge.
    // Checking comes first so a write result and the next request on the
    // same edge are matched in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (due_pixels.size() == 0)
                begin
                    flag_mismatch("result strobe with no request pending", 32'(result), 0);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (result.out_red !== want.out_red)
                        flag_mismatch("out_red", 32'(result.out_red), 32'(want.out_red));
                    if (result.out_green !== want.out_green)
                        flag_mismatch("out_green", 32'(result.out_green),
                                      32'(want.out_green));
                    if (result.out_blue !== want.out_blue)
                        flag_mismatch("out_blue", 32'(result.out_blue), 32'(want.out_blue));
                    if (result.coord_error !== want.coord_error)
                        flag_mismatch("coord_error", 32'(result.coord_error),
                                      32'(want.coord_error));
                end
            end
            if (cfg_we)
            begin
                n_cfg++;
                case (cfg_index)
                    CFG_FILTER_MODE: mode_cfg   = cfg_data[1:0];
                    CFG_SRC_WIDTH:   width_cfg  = cfg_data;
                    CFG_SRC_HEIGHT:  height_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                want = upscale_pixel(cmd);
                due_pixels.push_back(want);
                if (want.coord_error)
                    n_oob++;
                if (cmd.func == FUNC_WRITE)
                begin
                    n_writes++;
                end
                else
                begin
                    n_computes++;
                    if (!want.coord_error)
                        comp_by_mode[mode_cfg]++;
                end
                req_taken <= 1'b1;
            end
            else
            begin
                req_taken <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, due_pixels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: reset config (bicubic 128x128), writes at the corner
        // and past both edges of the source.
        cur_gap = 36;
        add_write(0, 0, 8'd255, 8'd255, 8'd255);
        add_write(255, 3, 8'd17, 8'd34, 8'd51);
        add_write(3, 128, 8'd0, 8'd0, 8'd0);

        // Undefined mode 3 runs as bicubic; height 0 saturates to one row.
        // A 0/255/255/0 row overshoots, 255/0/0/255 undershoots.
        add_config(CFG_FILTER_MODE, CFG_DATA_BITS'(3));
        add_config(CFG_SRC_WIDTH, CFG_DATA_BITS'(4));
        add_config(CFG_SRC_HEIGHT, CFG_DATA_BITS'(0));
        add_write(0, 0, 8'd0,   8'd255, 8'd0);
        add_write(1, 0, 8'd255, 8'd0,   8'd0);
        add_write(2, 0, 8'd255, 8'd0,   8'd255);
        add_write(3, 0, 8'd0,   8'd255, 8'd255);
        for (int x = 0; x < 8; x++)
            add_compute(x, 0);
        add_compute(3, 1);
        add_compute(8, 0);          // one past the destination width
        add_compute(0, 2);          // one past the destination height
        add_compute(255, 255);

        // Random phases: sender idles 36%, then 77%, then never.
        random_phase(MODE_NEAREST, 16, 12, 150);
        random_phase(MODE_BILINEAR, 0, 9, 90);
        random_phase(MODE_BICUBIC, 7, 200, 110);
        cur_gap = 77;
        random_phase(2'd3, 128, 3, 130);
        random_phase(MODE_BILINEAR, 5, 5, 130);
        random_phase(MODE_BICUBIC, 1, 1, 50);
        cur_gap = 0;
        random_phase(MODE_NEAREST, 255, 2, 100);
        random_phase(MODE_BICUBIC, 10, 10, 200);
        random_phase(MODE_BILINEAR, 128, 128, 100);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Look just after the falling edge so the feeder's update is visible
        do
        begin
            @(negedge clk);
            #1;
        end
        while (cmd_backlog.size() != 0 || start || due_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (due_pixels.size() != 0)
            flag_mismatch("results never returned", due_pixels.size(), 0);

        $display("Run covered %0d pixel writes and %0d computes (nearest %0d, bilinear %0d, %s",
                 n_writes, n_computes, comp_by_mode[0], comp_by_mode[1],
                 $sformatf("bicubic %0d, mode 3 %0d)", comp_by_mode[2], comp_by_mode[3]));
        $display("%0d out-of-range requests, %0d register writes, %0d mismatches in %0d cycles",
                 n_oob, n_cfg, err_count, cycle_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
